### sv/fbri_pkg.sv
// ----------------------------------------------------------------------------
// fbri_pkg
// Shared types and constants for the framebuffer rectangle invert block.
// ----------------------------------------------------------------------------
package fbri_pkg;

  localparam int unsigned ADDR_W     = 13;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned COORD_W    = 10;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned ROWB_W     = 8;
  localparam int unsigned ROT_W      = 2;
  localparam int unsigned PIX_ADDR_W = 20;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_INVERT = 2'd2;

  localparam logic [ROT_W-1:0] ROT_0   = 2'd0;
  localparam logic [ROT_W-1:0] ROT_90  = 2'd1;
  localparam logic [ROT_W-1:0] ROT_180 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_270 = 2'd3;

  localparam logic [DATA_W-1:0] BIT_MSB = 8'h80;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROTATION,
    REG_WIDTH_MEMORY,
    REG_HEIGHT_MEMORY,
    REG_ROW_BYTES
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDWAIT,
    ST_WALK,
    ST_DONE
  } fbri_state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [ADDR_W-1:0]  byte_address;
    logic [DATA_W-1:0]  write_data;
    logic [COORD_W-1:0] rect_x;
    logic [COORD_W-1:0] rect_y;
    logic [SIZE_W-1:0]  rect_w;
    logic [SIZE_W-1:0]  rect_h;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              nothing_done;
  } out_item_t;

  typedef struct packed {
    logic [ROT_W-1:0]  rotation;
    logic [DIM_W-1:0]  width_memory;
    logic [DIM_W-1:0]  height_memory;
    logic [ROWB_W-1:0] row_bytes;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIM_W-1:0] x0;
    logic [DIM_W-1:0] xe;
    logic [DIM_W-1:0] y0;
    logic [DIM_W-1:0] ye;
  } walk_start_t;

  typedef struct packed {
    logic             valid;
    logic [DIM_W-1:0] xd;
    logic [DIM_W-1:0] yd;
  } pixel_t;

endpackage

### sv/fbri_ram.sv
// ----------------------------------------------------------------------------
// fbri_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fbri_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/fbri_walk.sv
// ----------------------------------------------------------------------------
// fbri_walk
// Raster walker: emits one display pixel per cycle over a clipped rectangle.
// ----------------------------------------------------------------------------
module fbri_walk (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  fbri_pkg::walk_start_t start_i,
  output fbri_pkg::pixel_t     pixel_o
);
  import fbri_pkg::*;

  logic             active_q, active_d;
  logic [DIM_W-1:0] xd_q, xd_d, yd_q, yd_d;
  logic [DIM_W-1:0] x0_q, xe_q, ye_q;
  logic             row_end, last;

  assign row_end = (xd_q + DIM_W'(1)) == xe_q;
  assign last    = row_end && ((yd_q + DIM_W'(1)) == ye_q);

  always_comb begin
    active_d = active_q;
    xd_d     = xd_q;
    yd_d     = yd_q;
    if (start_i.start) begin
      active_d = 1'b1;
      xd_d     = start_i.x0;
      yd_d     = start_i.y0;
    end else if (active_q) begin
      if (row_end) begin
        xd_d = x0_q;
        yd_d = yd_q + DIM_W'(1);
      end else begin
        xd_d = xd_q + DIM_W'(1);
      end
      if (last) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else begin
      active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xd_q <= xd_d;
    yd_q <= yd_d;
    if (start_i.start) begin
      x0_q <= start_i.x0;
      xe_q <= start_i.xe;
      ye_q <= start_i.ye;
    end
  end

  assign pixel_o.valid = active_q;
  assign pixel_o.xd    = xd_q;
  assign pixel_o.yd    = yd_q;

endmodule

### sv/fbri_rmw.sv
// ----------------------------------------------------------------------------
// fbri_rmw
// Pixel pipeline: rotate to memory coordinates, form the byte address, then
// read, flip the bit and write back, forwarding the previous write.
// ----------------------------------------------------------------------------
module fbri_rmw #(
  parameter int unsigned FB_BYTES = 8192
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fbri_pkg::cfg_t              cfg_i,
  input  fbri_pkg::pixel_t            pixel_i,
  output logic                        re_o,
  output logic [$clog2(FB_BYTES)-1:0] raddr_o,
  input  logic [fbri_pkg::DATA_W-1:0] rdata_i,
  output logic                        we_o,
  output logic [$clog2(FB_BYTES)-1:0] waddr_o,
  output logic [fbri_pkg::DATA_W-1:0] wdata_o,
  output logic                        busy_o
);
  import fbri_pkg::*;

  localparam int unsigned MEM_AW = $clog2(FB_BYTES);

  logic signed [DIM_W:0] xm, ym;
  logic signed [DIM_W:0] xd_s, yd_s, w_s, h_s;
  logic                  map_ok;

  logic             m_valid_q;
  logic [DIM_W-1:0] m_xm_q, m_ym_q;

  logic [PIX_ADDR_W-1:0] addr_full;
  logic                  in_store;

  logic              a_valid_q;
  logic [MEM_AW-1:0] a_addr_q;
  logic [DATA_W-1:0] a_mask_q;

  logic              f_valid_q;
  logic [MEM_AW-1:0] f_addr_q;
  logic [DATA_W-1:0] f_data_q;
  logic [DATA_W-1:0] old_data, new_data;

  assign xd_s = $signed({1'b0, pixel_i.xd});
  assign yd_s = $signed({1'b0, pixel_i.yd});
  assign w_s  = $signed({1'b0, cfg_i.width_memory});
  assign h_s  = $signed({1'b0, cfg_i.height_memory});

  always_comb begin
    case (cfg_i.rotation)
      ROT_0: begin
        xm = yd_s;
        ym = xd_s;
      end
      ROT_90: begin
        xm = xd_s;
        ym = h_s - yd_s - 12'sd1;
      end
      ROT_180: begin
        xm = w_s - yd_s - 12'sd1;
        ym = h_s - xd_s - 12'sd1;
      end
      default: begin
        xm = w_s - xd_s - 12'sd1;
        ym = yd_s;
      end
    endcase
  end

  assign map_ok = !xm[DIM_W] && !ym[DIM_W]
               && (xm[DIM_W-1:0] < cfg_i.width_memory)
               && (ym[DIM_W-1:0] < cfg_i.height_memory);

  assign addr_full = PIX_ADDR_W'(m_ym_q) * PIX_ADDR_W'(cfg_i.row_bytes)
                   + PIX_ADDR_W'(m_xm_q[DIM_W-1:3]);
  assign in_store  = addr_full < PIX_ADDR_W'(FB_BYTES);

  assign re_o    = m_valid_q && in_store;
  assign raddr_o = addr_full[MEM_AW-1:0];

  assign old_data = (f_valid_q && (f_addr_q == a_addr_q)) ? f_data_q : rdata_i;
  assign new_data = old_data ^ a_mask_q;

  assign we_o    = a_valid_q;
  assign waddr_o = a_addr_q;
  assign wdata_o = new_data;
  assign busy_o  = m_valid_q || a_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      a_valid_q <= 1'b0;
      f_valid_q <= 1'b0;
    end else begin
      m_valid_q <= pixel_i.valid && map_ok;
      a_valid_q <= m_valid_q && in_store;
      f_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    m_xm_q   <= xm[DIM_W-1:0];
    m_ym_q   <= ym[DIM_W-1:0];
    a_addr_q <= addr_full[MEM_AW-1:0];
    a_mask_q <= BIT_MSB >> m_xm_q[2:0];
    f_addr_q <= a_addr_q;
    f_data_q <= new_data;
  end

endmodule

### sv/framebuffer_rect_invert_top.sv
// ----------------------------------------------------------------------------
// framebuffer_rect_invert_top
// One-bit-per-pixel framebuffer with byte access and rotated rectangle invert.
// ----------------------------------------------------------------------------
// A byte write is accepted in the idle state and passes to the done state,
// which loads the result into the output register; a byte read passes
// through the read wait state in between. An invert starts the walker, which
// issues one pixel per cycle into a map, address and read-modify-write
// pipeline on the single frame store, with the previous write forwarded, and
// the pipeline drains before the result is loaded. A finished item waits while
// the output register still holds an untaken result. One item is worked at a
// time; the next is accepted while the last result waits to be taken. The frame
// store has no reset and must be written before it is read.
module framebuffer_rect_invert_top #(
  parameter int unsigned FB_BYTES = 8192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fbri_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [fbri_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  fbri_pkg::in_item_t              in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output fbri_pkg::out_item_t             out_item_o
);
  import fbri_pkg::*;

  localparam int unsigned MEM_AW = $clog2(FB_BYTES);

  fbri_state_e state_q, state_d;
  cfg_t        cfg_q;
  out_item_t   res_q, res_d;
  out_item_t   out_q;
  logic        out_valid_q;
  logic        rd_hit_q;

  logic                  in_accept;
  logic [PIX_ADDR_W-1:0] byte_ext;
  logic                  byte_in_store;
  logic [DIM_W-1:0]      dmx, dmy, xe, ye;
  logic [DIM_W:0]        xe_full, ye_full;
  logic                  empty;
  logic                  out_free;
  walk_start_t           walk_start;
  pixel_t                pixel;

  logic              rmw_re, rmw_we, rmw_busy;
  logic [MEM_AW-1:0] rmw_raddr, rmw_waddr;
  logic [DATA_W-1:0] rmw_wdata, ram_rdata;

  logic              ram_re, ram_we;
  logic [MEM_AW-1:0] ram_raddr, ram_waddr;
  logic [DATA_W-1:0] ram_wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_ROTATION:      cfg_q.rotation      <= cfg_data_i[ROT_W-1:0];
        REG_WIDTH_MEMORY:  cfg_q.width_memory  <= cfg_data_i[DIM_W-1:0];
        REG_HEIGHT_MEMORY: cfg_q.height_memory <= cfg_data_i[DIM_W-1:0];
        REG_ROW_BYTES:     cfg_q.row_bytes     <= cfg_data_i[ROWB_W-1:0];
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  assign byte_ext      = PIX_ADDR_W'(in_item_i.byte_address);
  assign byte_in_store = byte_ext < PIX_ADDR_W'(FB_BYTES);

  always_comb begin
    if (cfg_q.rotation == ROT_0 || cfg_q.rotation == ROT_180) begin
      dmx = cfg_q.height_memory;
      dmy = cfg_q.width_memory;
    end else begin
      dmx = cfg_q.width_memory;
      dmy = cfg_q.height_memory;
    end
  end

  assign xe_full = (DIM_W+1)'(in_item_i.rect_x) + (DIM_W+1)'(in_item_i.rect_w);
  assign ye_full = (DIM_W+1)'(in_item_i.rect_y) + (DIM_W+1)'(in_item_i.rect_h);
  assign xe      = (xe_full > (DIM_W+1)'(dmx)) ? dmx : xe_full[DIM_W-1:0];
  assign ye      = (ye_full > (DIM_W+1)'(dmy)) ? dmy : ye_full[DIM_W-1:0];
  assign empty   = (in_item_i.rect_w == '0) || (in_item_i.rect_h == '0)
                || (DIM_W'(in_item_i.rect_x) >= xe)
                || (DIM_W'(in_item_i.rect_y) >= ye)
                || (cfg_q.row_bytes == '0);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    res_d            = res_q;
    walk_start       = '0;
    walk_start.x0    = DIM_W'(in_item_i.rect_x);
    walk_start.xe    = xe;
    walk_start.y0    = DIM_W'(in_item_i.rect_y);
    walk_start.ye    = ye;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          res_d = '0;
          case (in_item_i.req_type)
            REQ_READ: state_d = ST_RDWAIT;
            REQ_INVERT: begin
              if (empty) begin
                res_d.nothing_done = 1'b1;
                state_d            = ST_DONE;
              end else begin
                walk_start.start = 1'b1;
                state_d          = ST_WALK;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_RDWAIT: begin
        res_d.read_data = rd_hit_q ? ram_rdata : '0;
        state_d         = ST_DONE;
      end
      ST_WALK: begin
        if (!pixel.valid && !rmw_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_accept) begin
      rd_hit_q <= byte_in_store;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    if (state_q == ST_IDLE) begin
      ram_re    = in_accept && (in_item_i.req_type == REQ_READ) && byte_in_store;
      ram_raddr = byte_ext[MEM_AW-1:0];
      ram_we    = in_accept && (in_item_i.req_type == REQ_WRITE) && byte_in_store;
      ram_waddr = byte_ext[MEM_AW-1:0];
      ram_wdata = in_item_i.write_data;
    end else begin
      ram_re    = rmw_re;
      ram_raddr = rmw_raddr;
      ram_we    = rmw_we;
      ram_waddr = rmw_waddr;
      ram_wdata = rmw_wdata;
    end
  end

  fbri_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .pixel_o (pixel)
  );

  fbri_rmw #(
    .FB_BYTES (FB_BYTES)
  ) u_rmw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .pixel_i (pixel),
    .re_o    (rmw_re),
    .raddr_o (rmw_raddr),
    .rdata_i (ram_rdata),
    .we_o    (rmw_we),
    .waddr_o (rmw_waddr),
    .wdata_o (rmw_wdata),
    .busy_o  (rmw_busy)
  );

  fbri_ram #(
    .WIDTH (DATA_W),
    .DEPTH (FB_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !pixel.valid && !rmw_busy)
    else $error("pixel pipeline active while idle");

  a_rmw_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rmw_we || rmw_re) |-> state_q == ST_WALK)
    else $error("pixel pipeline accesses store outside invert");

  a_read_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && in_item_i.req_type == REQ_READ |=> state_q == ST_RDWAIT)
    else $error("read item did not wait for store data");
`endif

endmodule
